@@ design/indexed_list_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// indexed list engine assertion macros
// same-cycle and next-cycle implication checks on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_UNIT_DEFINES_SVH
`define INDEXED_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ILE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("indexed list engine check failed");
`define ILE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed list engine check failed");
`else
`define ILE_ASSERT_IMP(lbl, ante, cons)
`define ILE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ design/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CMD_W    = 3;
   localparam int IDX_W    = 9;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 9;

   localparam logic [CMD_W-1:0] CMD_READ = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HEAD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TAIL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_AT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL  = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic load;
      logic decode;
      logic shift_rd;
      logic shift_wr;
      logic commit;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_insert;
      logic is_delete;
      logic ok;
      logic more;
   } dp_stat_type;

endpackage

@@ design/ile_datapath.sv @@
// ----------------------------------------------------------------------------
// ile_datapath
// entry memory, length, shift pointer and response word registers
// ----------------------------------------------------------------------------
module ile_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ile_pkg::CMD_W-1:0]           req_command,
   input  logic [ile_pkg::IDX_W-1:0]           req_index,
   input  logic signed [ile_pkg::DATA_W-1:0]   req_value,
   input  ile_pkg::ctl_cmd_type                cmd,
   output ile_pkg::dp_stat_type                stat,
   output logic [ile_pkg::STAT_W-1:0]          rsp_status,
   output logic                                rsp_found,
   output logic signed [ile_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [ile_pkg::LEN_W-1:0]           rsp_length
);
   import ile_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];

   logic [CMD_W-1:0]  cmd_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] val_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  ptr_ff, ptr_in;
   logic [STAT_W-1:0] status_ff;
   logic              found_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic [LEN_W-1:0]  pos;
   logic              in_range;
   logic              full;
   logic [LEN_W-1:0]  src;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [STAT_W-1:0] status_in;

   always_comb begin
      stat.is_read   = (cmd_ff == CMD_READ);
      stat.is_insert = cmd_ff inside {CMD_HEAD, CMD_TAIL, CMD_AT};
      stat.is_delete = (cmd_ff == CMD_DEL);
      case (cmd_ff)
         CMD_HEAD: pos = '0;
         CMD_TAIL: pos = len_ff;
         default:  pos = LEN_W'(idx_ff);
      endcase
      full = (len_ff == LEN_W'(CAPACITY));
      if (stat.is_insert) begin
         in_range  = (pos <= len_ff);
         stat.ok   = in_range && !full;
         status_in = !in_range ? ST_RANGE : (full ? ST_FULL : ST_DONE);
         stat.more = (ptr_ff > pos);
         src       = ptr_ff - LEN_W'(1);
         ptr_in    = ptr_ff - LEN_W'(1);
      end else begin
         in_range  = (LEN_W'(idx_ff) < len_ff);
         stat.ok   = in_range;
         status_in = (stat.is_read || stat.is_delete) && !in_range ? ST_RANGE : ST_DONE;
         stat.more = ({1'b0, ptr_ff} + (LEN_W+1)'(1)) < {1'b0, len_ff};
         src       = ptr_ff + LEN_W'(1);
         ptr_in    = ptr_ff + LEN_W'(1);
      end
      len_in  = stat.is_insert ? len_ff + LEN_W'(1) : len_ff - LEN_W'(1);
      rd_en   = (cmd.decode && stat.is_read && in_range) || cmd.shift_rd;
      rd_addr = cmd.shift_rd ? src[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
      wr_en   = cmd.shift_wr || (cmd.commit && stat.is_insert);
      wr_addr = cmd.commit ? pos[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];
      wr_data = cmd.commit ? val_ff : rd_data_ff;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (cmd.commit) begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         idx_ff <= req_index;
         val_ff <= $unsigned(req_value);
      end
      if (cmd.decode) begin
         status_ff <= status_in;
         found_ff  <= stat.is_read && in_range;
         ptr_ff    <= stat.is_insert ? len_ff : LEN_W'(idx_ff);
      end else if (cmd.shift_wr) begin
         ptr_ff <= ptr_in;
      end
      if (cmd.rsp_load) begin
         rsp_status     <= status_ff;
         rsp_found      <= found_ff;
         rsp_read_value <= found_ff ? $signed(rd_data_ff) : '0;
         rsp_length     <= len_ff;
      end
   end

endmodule

@@ design/ile_controller.sv @@
// ----------------------------------------------------------------------------
// ile_controller
// sequences decode, the element shift loop, commit and response handoff
// ----------------------------------------------------------------------------
module ile_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ile_pkg::dp_stat_type  stat,
   output ile_pkg::ctl_cmd_type  cmd
);
   import ile_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_CHK    = 3'd2;
   localparam logic [2:0] S_RD     = 3'd3;
   localparam logic [2:0] S_WR     = 3'd4;
   localparam logic [2:0] S_LAST   = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if ((stat.is_insert || stat.is_delete) && stat.ok) begin
               state_in = S_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CHK: begin
            state_in = stat.more ? S_RD : S_LAST;
         end
         S_RD: begin
            cmd.shift_rd = 1'b1;
            state_in     = S_WR;
         end
         S_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_CHK;
         end
         S_LAST: begin
            cmd.commit = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/indexed_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// ordered list of signed words with read, insert and delete by position
// ----------------------------------------------------------------------------
// the request channel (req_valid/req_ready) carries one command word:
// command, index and value. the response channel (rsp_valid/rsp_ready)
// returns one word per command: status, found, read_value and length.
// entries live in a single-port style memory (one read, one write per
// cycle), so insert and delete move the tail of the list one entry at a
// time through a read/write/check loop.
// a read, a rejected command or an unused code goes from decode straight
// to the response; an insert or delete that moves k entries (k up to 255)
// runs the loop k times and then commits. a new word is taken the cycle
// after the response is loaded, so the block works on one command at a time.
// a finished response sits in the output register while the next command
// is accepted and worked on; only the final handoff waits for rsp_ready.
// reset empties the list and drops any pending response; memory contents
// are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ile_pkg::CMD_W-1:0]           req_command,
   input  logic [ile_pkg::IDX_W-1:0]           req_index,
   input  logic signed [ile_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ile_pkg::STAT_W-1:0]          rsp_status,
   output logic                                rsp_found,
   output logic signed [ile_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [ile_pkg::LEN_W-1:0]           rsp_length
);
   import ile_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   ile_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   ile_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_index      (req_index),
      .req_value      (req_value),
      .cmd            (ctl_cmd),
      .stat           (dp_stat),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_length)
   );

`include "indexed_list_engine_unit_defines.svh"

   `ILE_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `ILE_ASSERT_IMP(a_len_bound, rsp_valid, rsp_length <= LEN_W'(CAPACITY))
   `ILE_ASSERT_IMP(a_found_done, rsp_valid && rsp_found, rsp_status == ST_DONE)
   `ILE_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp_found, rsp_read_value == '0)

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the indexed list engine: a directed table of
// commands, then random command runs with one fill-to-capacity pass, each
// response checked against the table or a positional list model in the bench
// ----------------------------------------------------------------------------
module tb_top;
   import ile_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   localparam int RANDOM_ITEMS = 1250;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_CAP    = 100;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic signed [DATA_W-1:0] VAL_NEG = 32'hffff_ffff;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         length;
   } list_rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] val;
      logic                     typed;
      list_rsp_type             want;
   } list_cmd_row_type;

   localparam list_cmd_row_type DIRECTED_TABLE [24] = '{
      '{CMD_READ,    9'd0,   32'd0,        1'b1, '{ST_RANGE, 1'b0, 32'd0,   9'd0}},
      '{CMD_DEL,     9'd0,   32'd0,        1'b1, '{ST_RANGE, 1'b0, 32'd0,   9'd0}},
      '{CMD_AT,      9'd1,   32'h1111_1111, 1'b1, '{ST_RANGE, 1'b0, 32'd0,   9'd0}},
      '{CMD_READ,    9'd511, 32'd0,        1'b1, '{ST_RANGE, 1'b0, 32'd0,   9'd0}},
      '{CMD_AT,      9'd0,   VAL_MAX,      1'b1, '{ST_DONE,  1'b0, 32'd0,   9'd1}},
      '{CMD_HEAD,    9'd0,   VAL_MIN,      1'b1, '{ST_DONE,  1'b0, 32'd0,   9'd2}},
      '{CMD_TAIL,    9'd511, 32'd0,        1'b1, '{ST_DONE,  1'b0, 32'd0,   9'd3}},
      '{CMD_TAIL,    9'd0,   VAL_NEG,      1'b1, '{ST_DONE,  1'b0, 32'd0,   9'd4}},
      '{CMD_READ,    9'd0,   32'd0,        1'b1, '{ST_DONE,  1'b1, VAL_MIN, 9'd4}},
      '{CMD_READ,    9'd1,   32'd0,        1'b1, '{ST_DONE,  1'b1, VAL_MAX, 9'd4}},
      '{CMD_READ,    9'd3,   32'd0,        1'b1, '{ST_DONE,  1'b1, VAL_NEG, 9'd4}},
      '{CMD_READ,    9'd4,   32'd0,        1'b1, '{ST_RANGE, 1'b0, 32'd0,   9'd4}},
      '{CMD_AT,      9'd4,   32'h1234_5678, 1'b0, '0},
      '{CMD_AT,      9'd2,   32'ha5a5_a5a5, 1'b0, '0},
      '{CMD_AT,      9'd511, VAL_NEG,      1'b1, '{ST_RANGE, 1'b0, 32'd0,   9'd6}},
      '{CMD_SPARE_A, 9'd0,   VAL_MAX,      1'b1, '{ST_DONE,  1'b0, 32'd0,   9'd6}},
      '{CMD_SPARE_B, 9'd2,   VAL_MIN,      1'b1, '{ST_DONE,  1'b0, 32'd0,   9'd6}},
      '{CMD_SPARE_C, 9'd511, VAL_NEG,      1'b1, '{ST_DONE,  1'b0, 32'd0,   9'd6}},
      '{CMD_DEL,     9'd511, 32'd0,        1'b1, '{ST_RANGE, 1'b0, 32'd0,   9'd6}},
      '{CMD_DEL,     9'd0,   32'd0,        1'b0, '0},
      '{CMD_DEL,     9'd4,   32'd0,        1'b0, '0},
      '{CMD_READ,    9'd2,   32'd0,        1'b0, '0},
      '{CMD_DEL,     9'd1,   32'd0,        1'b0, '0},
      '{CMD_HEAD,    9'd0,   32'h5a5a_5a5a, 1'b0, '0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command = '0;
   logic [IDX_W-1:0]         req_index = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_found;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [LEN_W-1:0]         rsp_length;

   indexed_list_engine_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bench copy of the list
   logic signed [DATA_W-1:0] list_mem [CAPACITY];
   int                       list_len = 0;

   list_rsp_type pending_rsp_q [$];
   list_rsp_type rsp_want;
   int        mismatches = 0;
   int        items_sent = 0;
   int        burst_left = 0;
   int        idle_cycles = 0;
   logic [7:0] stall_mask = 8'hff;
   logic [2:0] stall_phase = '0;
   int         stall_age = 0;

   function automatic logic [STAT_W-1:0] list_insert(input int pos,
                                                     input logic signed [DATA_W-1:0] val);
      if (pos > list_len) return ST_RANGE;
      if (list_len >= CAPACITY) return ST_FULL;
      for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
      list_mem[pos] = val;
      list_len++;
      return ST_DONE;
   endfunction

   function automatic list_rsp_type apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic signed [DATA_W-1:0] val);
      list_rsp_type r;
      int        pos;
      r   = '0;
      pos = int'(idx);
      case (cmd)
         CMD_READ: begin
            if (pos < list_len) begin
               r.found      = 1'b1;
               r.read_value = list_mem[pos];
            end else begin
               r.status = ST_RANGE;
            end
         end
         CMD_HEAD: r.status = list_insert(0, val);
         CMD_TAIL: r.status = list_insert(list_len, val);
         CMD_AT:   r.status = list_insert(pos, val);
         CMD_DEL: begin
            if (pos < list_len) begin
               for (int i = pos; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end else begin
               r.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      r.length = LEN_W'(list_len);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val, input logic typed,
                            input list_rsp_type want);
      int        gap;
      list_rsp_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_index   <= idx;
      req_value   <= val;
      do @(posedge clock); while (!req_ready);
      predicted = apply_list_cmd(cmd, idx, val);
      pending_rsp_q.push_back(typed ? want : predicted);
      if (cmd <= CMD_DEL) items_sent++;
   endtask

   task automatic random_list_op(input logic noise);
      logic [CMD_W-1:0]         cmd;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] val;
      int                       pick;
      int                       del_weight;
      if (noise) begin
         cmd = CMD_W'($urandom_range(0, 7));
      end else begin
         del_weight = (list_len > 24) ? 50 : 22;
         pick = $urandom_range(0, 99);
         if (list_len == 0) pick = $urandom_range(30, 69);
         if (pick < 30) cmd = CMD_READ;
         else if (pick < 42) cmd = CMD_HEAD;
         else if (pick < 54) cmd = CMD_TAIL;
         else if (pick < 70) cmd = CMD_AT;
         else if (pick < 70 + del_weight) cmd = CMD_DEL;
         else if (pick < 96) cmd = CMD_READ;
         else cmd = CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
      end
      if (noise || $urandom_range(0, 6) == 0) idx = IDX_W'($urandom_range(0, 511));
      else idx = IDX_W'($urandom_range(0, list_len));
      case ($urandom_range(0, 11))
         0:       val = VAL_MIN;
         1:       val = VAL_MAX;
         2:       val = VAL_NEG;
         3:       val = '0;
         default: val = $urandom;
      endcase
      send_word(cmd, idx, val, 1'b0, '0);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_phase <= '0;
         stall_age   <= 0;
      end else begin
         if (stall_age == 0) begin
            stall_mask <= ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
            stall_age  <= $urandom_range(50, 300);
         end else begin
            stall_age <= stall_age - 1;
         end
         stall_phase <= stall_phase + 3'd1;
         rsp_ready   <= stall_mask[stall_phase];
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("response word with nothing pending");
         end else begin
            rsp_want = pending_rsp_q.pop_front();
            if (rsp_status !== rsp_want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_status, rsp_want.status));
            if (rsp_found !== rsp_want.found)
               report_mismatch($sformatf("found got %0d want %0d",
                                         rsp_found, rsp_want.found));
            if (rsp_read_value !== rsp_want.read_value)
               report_mismatch($sformatf("read_value got %0d want %0d",
                                         rsp_read_value, rsp_want.read_value));
            if (rsp_length !== rsp_want.length)
               report_mismatch($sformatf("length got %0d want %0d",
                                         rsp_length, rsp_want.length));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic filled;
      int   run_len;
      logic noise;
      filled = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 24; i++)
         send_word(DIRECTED_TABLE[i].cmd, DIRECTED_TABLE[i].idx, DIRECTED_TABLE[i].val,
                   DIRECTED_TABLE[i].typed, DIRECTED_TABLE[i].want);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (!filled && items_sent >= 300) begin
            filled = 1'b1;
            while (list_len < CAPACITY) send_word(CMD_TAIL, IDX_W'($urandom), $urandom, 1'b0, '0);
            send_word(CMD_HEAD, '0, $urandom, 1'b0, '0);
            send_word(CMD_TAIL, '0, $urandom, 1'b0, '0);
            send_word(CMD_AT, IDX_W'($urandom_range(0, CAPACITY)), $urandom, 1'b0, '0);
            send_word(CMD_AT, IDX_W'($urandom_range(CAPACITY + 1, 511)), $urandom, 1'b0, '0);
            send_word(CMD_READ, IDX_W'(CAPACITY - 1), '0, 1'b0, '0);
            send_word(CMD_READ, IDX_W'(CAPACITY), '0, 1'b0, '0);
            send_word(CMD_DEL, IDX_W'($urandom_range(0, 15)), '0, 1'b0, '0);
            send_word(CMD_AT, IDX_W'($urandom_range(0, 15)), $urandom, 1'b0, '0);
            send_word(CMD_AT, IDX_W'(CAPACITY), $urandom, 1'b0, '0);
            while (list_len > 8) begin
               if ($urandom_range(0, 9) == 0)
                  send_word(CMD_DEL, IDX_W'($urandom_range(0, list_len - 1)), '0, 1'b0, '0);
               else if ($urandom_range(0, 5) == 0)
                  send_word(CMD_READ, IDX_W'($urandom_range(0, list_len)), '0, 1'b0, '0);
               else
                  send_word(CMD_DEL, IDX_W'(list_len - 1), '0, 1'b0, '0);
            end
         end else begin
            run_len = $urandom_range(8, 40);
            noise   = ($urandom_range(0, 9) == 0);
            repeat (run_len) random_list_op(noise);
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
